// ===== rtl/core/pixel_hit_stream_decoder_core_defines.svh =====
// assertion macros for the pixel hit stream decoder core
// expects aclk and aresetn in the scope where the macros are used
`ifndef PIXEL_HIT_STREAM_DECODER_CORE_DEFINES_SVH
`define PIXEL_HIT_STREAM_DECODER_CORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PHSD_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("phsd assertion failed");

// antecedent at one edge implies consequent at the next edge
`define PHSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phsd assertion failed");

`endif

// ===== rtl/core/phsd_pkg.sv =====
// shared types and constants of the pixel hit stream decoder core
// no dependencies
`default_nettype none

package phsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    localparam int TDATA_W  = 120;
    localparam int ADDR_W   = 19;
    localparam int HITMAP_W = 7;

    localparam logic [7:0] HDR_SYNC_BYTE = 8'hAA;
    localparam logic [7:0] IDLE_BYTE     = 8'hFF;
    localparam logic [3:0] NIB_EMPTY     = 4'hE;
    localparam logic [3:0] NIB_CHIP_HDR  = 4'hA;
    localparam logic [3:0] NIB_TRAILER   = 4'hB;
    localparam logic [1:0] TOP2_LONG     = 2'b00;
    localparam logic [1:0] TOP2_SHORT    = 2'b01;
    localparam logic [2:0] TOP3_REGION   = 3'b110;
    localparam logic [63:0] STRAY_TIME   = 64'd2;

    typedef enum logic [1:0] {
        KIND_HIT   = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_HEADER = 2'd0,
        ERR_EMPTY  = 2'd1,
        ERR_DATA   = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_FRAME  = 4'd1,
        PH_EMPTY  = 4'd2,
        PH_BC     = 4'd3,
        PH_DATA   = 4'd4,
        PH_SHORT2 = 4'd5,
        PH_LONG2  = 4'd6,
        PH_LONG3  = 4'd7,
        PH_SKIP   = 4'd8,
        PH_ERR    = 4'd9
    } phase_t;

    // one queued command: a single result, or a hitmap that expands to hits
    typedef struct packed {
        kind_t                 kind;
        err_t                  err;
        logic [31:0]           evn;
        logic [63:0]           ts;
        logic [ADDR_W-1:0]     addr;
        logic [HITMAP_W-1:0]   hitmap;
        logic                  is_map;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pixel_hit_stream_decoder_core.sv =====
// top level of the pixel hit stream decoder core
// depends on phsd_pkg, phsd_front, phsd_queue, phsd_back and the defines header
`default_nettype none
`include "pixel_hit_stream_decoder_core_defines.svh"

// Takes one readout byte per cycle while s_tready is high and decodes event headers, empty
// frames, chip frames with region, short and long hit words and trailers into event start,
// hit, event end and error items. The results of a byte pass through the command queue into
// the output register, one per cycle while the output is not stalled. A long word yields up
// to eight results (the base hit with its second byte, up to seven hitmap hits with its
// third), so the back end expands a hitmap byte into one result per hit. A four-entry command
// queue between the byte parser and the result expander absorbs such bursts; s_tready drops
// only while that queue is full. After an error, bytes are taken and dropped until a byte
// with the buffer start flag.

module pixel_hit_stream_decoder_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          s_tuser,   // buffer_start
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [phsd_pkg::TDATA_W-1:0] m_tdata,
    // event_number[31:0], timestamp[95:32], hit_x[105:96], hit_y[114:106],
    // error_code[116:115], zero pad[119:117]
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last
);
    import phsd_pkg::*;

    cmd_t               f_cmd, q_head;
    logic               f_push, q_pop, q_empty, q_full, s_accept;
    logic [QCNT_W-1:0]  q_count;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    phsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid   (s_accept),
        .data_byte    (s_tdata),
        .buffer_start (s_tuser),
        .cmd          (f_cmd),
        .cmd_push     (f_push)
    );

    phsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (f_push),
        .push_cmd (f_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    phsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `PHSD_ASSERT(a_queue_bound, q_count <= QUEUE_FULL_CNT)
    `PHSD_ASSERT(a_pop_nonempty, !(q_pop && q_empty))
    `PHSD_ASSERT_NEXT(a_pop_closes_item, q_pop, m_tvalid && m_tlast)
    `PHSD_ASSERT(a_err_no_pixel, !(m_tvalid && m_tuser == KIND_ERROR && m_tdata[114:96] != 19'd0))

endmodule

`default_nettype wire

// ===== rtl/core/phsd_front.sv =====
// front end: parses the byte stream and issues one command per result-causing item
// depends on phsd_pkg
`default_nettype none

module phsd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    data_byte,
    input  wire logic          buffer_start,
    output phsd_pkg::cmd_t     cmd,
    output logic               cmd_push
);
    import phsd_pkg::*;

    phase_t              phase_reg, phase_next, ph_cur;
    logic [3:0]          fbc_reg, fbc_next, fbc_cur;
    logic [31:0]         evn_reg, evn_next;
    logic [63:0]         ts_reg, ts_next, ts_shift;
    logic [4:0]          region_reg, region_next, region_cur;
    logic [ADDR_W-1:0]   paddr_reg, paddr_next;
    logic [1:0]          woff_reg, woff_next, pos, nxt;
    logic                fhp_reg, fhp_next, fhp_cur;
    logic [2:0]          skip_reg, skip_next, skip_cur, skip_dec;
    logic                stray, hdr_bad, empty_bad, emit;
    kind_t               c_kind;
    err_t                c_err;
    logic [ADDR_W-1:0]   c_addr;
    logic                c_map;

    // buffer start restarts parsing with this item
    assign ph_cur     = buffer_start ? PH_HDR : phase_reg;
    assign fbc_cur    = buffer_start ? 4'd0 : fbc_reg;
    assign fhp_cur    = buffer_start ? 1'b1 : fhp_reg;
    assign pos        = buffer_start ? 2'd0 : woff_reg;
    assign skip_cur   = buffer_start ? 3'd0 : skip_reg;
    assign region_cur = buffer_start ? 5'd0 : region_reg;

    assign nxt       = pos + 2'd1;
    assign skip_dec  = (skip_cur != 3'd0) ? skip_cur - 3'd1 : 3'd0;
    assign ts_shift  = {data_byte, ts_reg[63:8]};
    assign stray     = fhp_cur && (evn_reg == 32'd0) && (ts_shift == STRAY_TIME);
    assign hdr_bad   = (fbc_cur < 4'd4) && (data_byte != HDR_SYNC_BYTE);
    assign empty_bad = (fbc_cur >= 4'd2) && (data_byte != IDLE_BYTE);

    // next phase
    always_comb begin
        phase_next = ph_cur;
        case (ph_cur)
            PH_HDR: begin
                if (hdr_bad) begin
                    phase_next = PH_ERR;
                end else if (fbc_cur == 4'd15 && !stray) begin
                    phase_next = PH_FRAME;
                end
            end
            PH_FRAME: begin
                if (data_byte[7:4] == NIB_EMPTY) begin
                    phase_next = PH_EMPTY;
                end else if (data_byte[7:4] == NIB_CHIP_HDR) begin
                    phase_next = PH_BC;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_EMPTY: begin
                if (empty_bad) begin
                    phase_next = PH_ERR;
                end else if (fbc_cur >= 4'd3) begin
                    phase_next = PH_SKIP;
                end
            end
            PH_BC: phase_next = PH_DATA;
            PH_DATA: begin
                if (data_byte[7:6] == TOP2_LONG) begin
                    phase_next = PH_LONG2;
                end else if (data_byte[7:6] == TOP2_SHORT) begin
                    phase_next = PH_SHORT2;
                end else if (data_byte[7:5] == TOP3_REGION) begin
                    phase_next = PH_DATA;
                end else if (data_byte[7:4] == NIB_TRAILER) begin
                    phase_next = PH_SKIP;
                end else if (data_byte != IDLE_BYTE) begin
                    phase_next = PH_ERR;
                end
            end
            PH_SHORT2: phase_next = PH_DATA;
            PH_LONG2:  phase_next = PH_LONG3;
            PH_LONG3:  phase_next = PH_DATA;
            PH_SKIP: begin
                if (skip_dec == 3'd0) begin
                    phase_next = PH_HDR;
                end
            end
            PH_ERR:  phase_next = PH_ERR;
            default: phase_next = PH_ERR;
        endcase
    end

    // datapath registers and command
    always_comb begin
        fbc_next    = fbc_cur;
        evn_next    = evn_reg;
        ts_next     = ts_reg;
        region_next = region_cur;
        paddr_next  = paddr_reg;
        fhp_next    = fhp_cur;
        skip_next   = skip_cur;
        woff_next   = nxt;
        emit        = 1'b0;
        c_kind      = KIND_HIT;
        c_err       = ERR_HEADER;
        c_addr      = '0;
        c_map       = 1'b0;
        case (ph_cur)
            PH_HDR: begin
                if (hdr_bad) begin
                    emit   = 1'b1;
                    c_kind = KIND_ERROR;
                    c_err  = ERR_HEADER;
                end else begin
                    if (fbc_cur inside {[4'd4:4'd7]}) begin
                        evn_next = {data_byte, evn_reg[31:8]};
                    end else if (fbc_cur >= 4'd8) begin
                        ts_next = ts_shift;
                    end
                    if (fbc_cur == 4'd15) begin
                        fbc_next = 4'd0;
                        fhp_next = 1'b0;
                        if (!stray) begin
                            emit   = 1'b1;
                            c_kind = KIND_START;
                        end
                    end else begin
                        fbc_next = fbc_cur + 4'd1;
                    end
                end
            end
            PH_FRAME: begin
                if (data_byte[7:4] == NIB_EMPTY) begin
                    fbc_next = 4'd1;
                end else if (data_byte[7:4] == NIB_CHIP_HDR) begin
                    region_next = 5'd0;
                end else begin
                    emit      = 1'b1;
                    c_kind    = KIND_END;
                    skip_next = 3'd3;
                end
            end
            PH_EMPTY: begin
                if (empty_bad) begin
                    emit   = 1'b1;
                    c_kind = KIND_ERROR;
                    c_err  = ERR_EMPTY;
                end else if (fbc_cur >= 4'd3) begin
                    emit      = 1'b1;
                    c_kind    = KIND_END;
                    fbc_next  = 4'd0;
                    skip_next = 3'd4;
                end else begin
                    fbc_next = fbc_cur + 4'd1;
                end
            end
            PH_DATA: begin
                if (data_byte[7:6] == TOP2_LONG || data_byte[7:6] == TOP2_SHORT) begin
                    paddr_next = {region_cur, data_byte[5:0], 8'h00};
                end else if (data_byte[7:5] == TOP3_REGION) begin
                    region_next = data_byte[4:0];
                end else if (data_byte[7:4] == NIB_TRAILER) begin
                    // skip to the next 4-byte boundary plus one word
                    emit      = 1'b1;
                    c_kind    = KIND_END;
                    skip_next = 3'd4 + {1'b0, 2'd0 - nxt};
                    fbc_next  = 4'd0;
                end else if (data_byte != IDLE_BYTE) begin
                    emit   = 1'b1;
                    c_kind = KIND_ERROR;
                    c_err  = ERR_DATA;
                end
            end
            PH_SHORT2: begin
                emit   = 1'b1;
                c_addr = paddr_reg | {11'd0, data_byte};
            end
            PH_LONG2: begin
                paddr_next = paddr_reg | {11'd0, data_byte};
                emit       = 1'b1;
                c_addr     = paddr_reg | {11'd0, data_byte};
            end
            PH_LONG3: begin
                emit   = (data_byte[HITMAP_W-1:0] != '0);
                c_addr = paddr_reg;
                c_map  = 1'b1;
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 3'd0) begin
                    fbc_next = 4'd0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.kind   = c_kind;
        cmd.err    = c_err;
        cmd.evn    = evn_next;
        cmd.ts     = ts_next;
        cmd.addr   = c_addr;
        cmd.hitmap = data_byte[HITMAP_W-1:0];
        cmd.is_map = c_map;
    end

    assign cmd_push = byte_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            fbc_reg    <= 4'd0;
            evn_reg    <= 32'd0;
            ts_reg     <= 64'd0;
            region_reg <= 5'd0;
            paddr_reg  <= '0;
            woff_reg   <= 2'd0;
            fhp_reg    <= 1'b1;
            skip_reg   <= 3'd0;
        end else if (byte_valid) begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            evn_reg    <= evn_next;
            ts_reg     <= ts_next;
            region_reg <= region_next;
            paddr_reg  <= paddr_next;
            woff_reg   <= woff_next;
            fhp_reg    <= fhp_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/phsd_queue.sv =====
// command queue between front end and back end
// depends on phsd_pkg
`default_nettype none

module phsd_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire phsd_pkg::cmd_t          push_cmd,
    input  wire logic                    pop,
    output phsd_pkg::cmd_t               head,
    output logic                         empty,
    output logic                         full,
    output logic [phsd_pkg::QCNT_W-1:0]  count
);
    import phsd_pkg::*;

    cmd_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QUEUE_FULL_CNT);
    assign count = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/phsd_back.sv =====
// back end: expands queued commands into registered results, one per unstalled cycle
// depends on phsd_pkg
`default_nettype none

module phsd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire phsd_pkg::cmd_t                head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [phsd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import phsd_pkg::*;

    logic [HITMAP_W-1:0]  done_reg, done_next, remaining, pick, rest;
    logic [2:0]           off;
    logic [ADDR_W-1:0]    hit_addr;
    logic                 is_final, load, is_hit;
    logic [9:0]           hx;
    logic [8:0]           hy;
    logic                 m_tvalid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    assign remaining = head.hitmap & ~done_reg;
    assign pick      = remaining & (~remaining + HITMAP_W'(1));
    assign rest      = remaining & ~pick;

    always_comb begin
        off = 3'd0;
        for (int i = 0; i < HITMAP_W; i++) begin
            if (pick[i]) begin
                off = 3'(i + 1);
            end
        end
    end

    assign hit_addr = head.is_map ? head.addr + ADDR_W'(off) : head.addr;
    assign is_final = !head.is_map || (rest == '0);
    assign load     = !empty && (!m_tvalid_reg || m_tready);
    assign pop      = load && is_final;
    assign is_hit   = (head.kind == KIND_HIT);

    // double column layout: column pair from the high bits, row from the low bits
    assign hx = is_hit ? {hit_addr[18:10], hit_addr[0] ^ hit_addr[1]} : 10'd0;
    assign hy = is_hit ? hit_addr[9:1] : 9'd0;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = is_final ? '0 : (done_reg | pick);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {3'd0, head.err, hy, hx, head.ts, head.evn};
            m_tuser_reg <= head.kind;
            m_tlast_reg <= is_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            done_reg     <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire
